// ===== rtl/core/sm4_pkg.sv =====
package sm4_pkg;

	localparam int ROUNDS    = 32;
	localparam int KEY_IDX_W = 5;
	localparam int WORD_W    = 32;
	localparam int NWORDS    = 4;
	localparam int HALF_W    = 64;

	typedef enum logic {
		MODE_KEY   = 1'b0,
		MODE_BLOCK = 1'b1
	} mode_t;

	// One request as it travels down the round pipeline; w[0] is X0.
	typedef struct packed {
		mode_t                          mode;
		logic [KEY_IDX_W-1:0]           key_index;
		logic [WORD_W-1:0]              key_word;
		logic [NWORDS-1:0][WORD_W-1:0]  w;
	} stage_t;

endpackage

// ===== rtl/core/sm4_ifs.sv =====
interface sm4_req_if;
	import sm4_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [KEY_IDX_W-1:0] key_index;
	logic [WORD_W-1:0]    key_word;
	logic [HALF_W-1:0]    block_high;
	logic [HALF_W-1:0]    block_low;

	modport source (output valid, mode, key_index, key_word, block_high, block_low,
		input ready);
	modport sink (input valid, mode, key_index, key_word, block_high, block_low,
		output ready);
endinterface

interface sm4_rsp_if;
	import sm4_pkg::*;

	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] result_high;
	logic [HALF_W-1:0] result_low;

	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

// ===== rtl/core/sm4_stage.sv =====
module sm4_stage import sm4_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [KEY_IDX_W-1:0] slot,
	input  logic                 vld_in,
	input  stage_t               d_in,
	output logic                 vld_out,
	output stage_t               d_out
);

	localparam logic [0:255][7:0] SBOX = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

	logic [WORD_W-1:0] rk_q;
	logic [WORD_W-1:0] mix_in;
	logic [WORD_W-1:0] sub;
	logic [WORD_W-1:0] lin;
	stage_t            nxt;
	logic              vld_s;
	stage_t            d_s;

	// Load this round's key as a key request passes; later blocks see it, earlier ones
	// have already left this round.
	always_ff @(posedge clk) begin
		if (advance && vld_in && d_in.mode == MODE_KEY && d_in.key_index == slot) begin
			rk_q <= d_in.key_word;
		end
	end

	always_comb begin
		mix_in = d_in.w[1] ^ d_in.w[2] ^ d_in.w[3] ^ rk_q;
		sub = {SBOX[mix_in[31:24]], SBOX[mix_in[23:16]],
			SBOX[mix_in[15:8]], SBOX[mix_in[7:0]]};
		lin = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
			^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
		nxt = d_in;
		nxt.w[0] = d_in.w[1];
		nxt.w[1] = d_in.w[2];
		nxt.w[2] = d_in.w[3];
		nxt.w[3] = d_in.w[0] ^ lin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (advance) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_s <= nxt;
		end
	end

	assign vld_out = vld_s;
	assign d_out   = d_s;

endmodule

// ===== rtl/core/sm4_block_cipher.sv =====
// Channel  Modport       Payload                                          Moves
// req      sm4_req_if    mode, key_index, key_word, block_high, block_low  one request
// rsp      sm4_rsp_if    result_high, result_low                          one result per block
//
// Throughput is one request per cycle unless an unread result stalls the output; a block
// passes the 32 round stages, each holding one S-box layer, linear layer and round key.
// Key loads ride the same pipeline and update their round's key as they pass it, so
// loads and blocks keep their order; key loads give no result and drop at the end.
// Reset clears only the stage valid bits; round keys hold garbage until loaded.
// An unread result freezes the whole pipeline; nothing is lost or repeated.
module sm4_block_cipher import sm4_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sm4_req_if.sink   req,
	sm4_rsp_if.source rsp
);

	logic          advance;
	logic [ROUNDS:0] vld_chain;
	stage_t        dat_chain [ROUNDS+1];

	// Hold every stage while a finished block waits at the output.
	assign advance   = !rsp.valid || rsp.ready;
	assign req.ready = advance;

	// Feed the first round straight from the request.
	always_comb begin
		vld_chain[0]           = req.valid;
		dat_chain[0].mode      = mode_t'(req.mode);
		dat_chain[0].key_index = req.key_index;
		dat_chain[0].key_word  = req.key_word;
		dat_chain[0].w[0]      = req.block_high[HALF_W-1:WORD_W];
		dat_chain[0].w[1]      = req.block_high[WORD_W-1:0];
		dat_chain[0].w[2]      = req.block_low[HALF_W-1:WORD_W];
		dat_chain[0].w[3]      = req.block_low[WORD_W-1:0];
	end

	// One stage per round; stage r owns round key r.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		sm4_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.slot    (KEY_IDX_W'(r)),
			.vld_in  (vld_chain[r]),
			.d_in    (dat_chain[r]),
			.vld_out (vld_chain[r+1]),
			.d_out   (dat_chain[r+1])
		);
	end

	// Drop key loads at the end; emit blocks with the words reversed.
	assign rsp.valid       = vld_chain[ROUNDS] && dat_chain[ROUNDS].mode == MODE_BLOCK;
	assign rsp.result_high = {dat_chain[ROUNDS].w[3], dat_chain[ROUNDS].w[2]};
	assign rsp.result_low  = {dat_chain[ROUNDS].w[1], dat_chain[ROUNDS].w[0]};

`ifndef SYNTHESIS
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> vld_chain[1])
		else $error("accepted request missing from first round stage");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(vld_chain[ROUNDS:1]))
		else $error("pipeline moved during output stall");

	a_rsp_is_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (vld_chain[ROUNDS] && dat_chain[ROUNDS].mode == MODE_BLOCK))
		else $error("result shown for a key load or bubble");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sm4_pkg::*;

	localparam int KEY_SLOTS      = 1 << KEY_IDX_W;
	localparam int PIPE_LATENCY   = ROUNDS;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 920;

	// S-box, entry 0 leftmost.
	localparam logic [0:255][7:0] SBOX = {
		128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
		128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
		128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
		128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
		128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
		128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
		128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
		128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
	};

	typedef struct packed {
		mode_t                mode;
		logic [KEY_IDX_W-1:0] key_index;
		logic [WORD_W-1:0]    key_word;
		logic [HALF_W-1:0]    block_high;
		logic [HALF_W-1:0]    block_low;
	} sm4_request_t;

	typedef struct packed {
		logic [HALF_W-1:0] result_high;
		logic [HALF_W-1:0] result_low;
	} sm4_block_t;

	logic clk;
	logic arst_n;

	sm4_req_if req_ch ();
	sm4_rsp_if rsp_ch ();

	sm4_block_cipher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Our own copy of the round-key store and the blocks still in flight.
	logic [WORD_W-1:0] key_copy [0:KEY_SLOTS-1];
	sm4_block_t        expected_blocks [$];

	int errors;
	int hold_off_cycles;	// set by a test, consumed by the receiver
	bit steady;		// no random gaps on either side while set
	bit req_up;		// valid is currently driven high

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Nonlinear S-box layer followed by the linear rotate-XOR layer.
	function automatic logic [WORD_W-1:0] sbox_linear_mix(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s;
		s = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
		return s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
			^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
	endfunction

	function automatic sm4_block_t sm4_transform(input logic [HALF_W-1:0] hi,
		input logic [HALF_W-1:0] lo);
		logic [WORD_W-1:0] x0, x1, x2, x3, nx;
		sm4_block_t r;
		x0 = hi[63:32];
		x1 = hi[31:0];
		x2 = lo[63:32];
		x3 = lo[31:0];
		for (int n = 0; n < ROUNDS; n++) begin
			nx = x0 ^ sbox_linear_mix(x1 ^ x2 ^ x3 ^ key_copy[n]);
			x0 = x1;
			x1 = x2;
			x2 = x3;
			x3 = nx;
		end
		// Words leave in reversed order.
		r.result_high = {x3, x2};
		r.result_low  = {x1, x0};
		return r;
	endfunction

	// Apply one accepted request to the predicted state.
	function automatic void apply_request(input sm4_request_t it);
		if (it.mode == MODE_KEY)
			key_copy[it.key_index] = it.key_word;
		else
			expected_blocks.push_back(sm4_transform(it.block_high, it.block_low));
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [HALF_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Block fields of a key load are ignored; fill them with junk.
	function automatic sm4_request_t key_request(input int idx, input logic [WORD_W-1:0] word);
		sm4_request_t it;
		it.mode       = MODE_KEY;
		it.key_index  = idx[KEY_IDX_W-1:0];
		it.key_word   = word;
		it.block_high = rand64();
		it.block_low  = rand64();
		return it;
	endfunction

	// Key fields of a block are ignored; fill them with junk.
	function automatic sm4_request_t block_request(input logic [HALF_W-1:0] hi,
		input logic [HALF_W-1:0] lo);
		sm4_request_t it;
		it.mode       = MODE_BLOCK;
		it.key_index  = KEY_IDX_W'($urandom_range(0, KEY_SLOTS - 1));
		it.key_word   = $urandom;
		it.block_high = hi;
		it.block_low  = lo;
		return it;
	endfunction

	// Offer one request after a random gap; return at the edge that takes it.
	// Sample ready at the falling edge so the check never races the block.
	task automatic send_request(input sm4_request_t it);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			if (req_up) begin
				req_ch.valid <= 1'b0;
				req_up = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= it.mode;
		req_ch.key_index  <= it.key_index;
		req_ch.key_word   <= it.key_word;
		req_ch.block_high <= it.block_high;
		req_ch.block_low  <= it.block_low;
		req_up = 1'b1;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			if (taken)
				apply_request(it);
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop valid; wait for a rising edge so a later raise lands in a fresh time step.
	task automatic req_idle();
		if (req_up) begin
			req_ch.valid <= 1'b0;
			req_up = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_idle();
		while (expected_blocks.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Write every slot before any block, so no block reads an unwritten key.
	task automatic test_key_fill();
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (i == 0)
				send_request(key_request(i, 32'h0000_0000));
			else if (i == KEY_SLOTS - 1)
				send_request(key_request(i, 32'hffff_ffff));
			else
				send_request(key_request(i, $urandom));
		end
	endtask

	task automatic test_block_extremes();
		send_request(block_request(64'h0, 64'h0));
		send_request(block_request({HALF_W{1'b1}}, {HALF_W{1'b1}}));
		send_request(block_request(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000));
		send_request(block_request(64'ha5a5_a5a5_5a5a_5a5a, 64'h5a5a_5a5a_a5a5_a5a5));
		send_request(block_request(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210));
		send_request(block_request(64'h0, {HALF_W{1'b1}}));
	endtask

	// Key loads travel with the blocks: a block behind a load must see the new
	// key, a block ahead of it the old one. Run back to back to stress that.
	task automatic test_key_update_order();
		steady = 1'b1;
		send_request(block_request(rand64(), rand64()));
		send_request(key_request(0, 32'hffff_ffff));
		send_request(block_request(rand64(), rand64()));
		send_request(key_request(KEY_SLOTS - 1, 32'h0000_0000));
		send_request(block_request(rand64(), rand64()));
		send_request(key_request(0, $urandom));
		send_request(key_request(0, 32'h0000_0000));
		send_request(block_request(rand64(), rand64()));
		steady = 1'b0;
	endtask

	// Decrypt: reload the keys reversed and feed back a ciphertext.
	task automatic test_decrypt();
		logic [WORD_W-1:0] fwd [0:KEY_SLOTS-1];
		sm4_block_t ct;
		ct = sm4_transform(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
		fwd = key_copy;
		for (int i = 0; i < KEY_SLOTS; i++)
			send_request(key_request(i, fwd[KEY_SLOTS - 1 - i]));
		send_request(block_request(ct.result_high, ct.result_low));
	endtask

	// Hold the receiver off long enough for the pipeline to fill and stall
	// the request side, while requests keep coming.
	task automatic test_backpressure();
		hold_off_cycles = LONG_HOLD;
		steady = 1'b1;
		for (int i = 0; i < 120; i++) begin
			if (i % 17 == 5)
				send_request(key_request($urandom_range(0, KEY_SLOTS - 1), $urandom));
			else
				send_request(block_request(rand64(), rand64()));
		end
		steady = 1'b0;
	endtask

	// Pause the sender until every result is back, then resume.
	task automatic test_drain_pause();
		for (int i = 0; i < 20; i++)
			send_request(block_request(rand64(), rand64()));
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_request(block_request(rand64(), rand64()));
	endtask

	// Mostly block traffic with sparse key updates, some full key reloads
	// in either direction, and some fully random requests.
	task automatic test_random();
		int sent, kind, burst;
		bit reverse;
		sm4_request_t it;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind   = $urandom_range(0, 99);
			burst  = $urandom_range(4, 40);
			steady = ($urandom_range(0, 9) == 0);
			if (kind < 8) begin
				reverse = 1'($urandom_range(0, 1));
				for (int i = 0; i < KEY_SLOTS; i++)
					send_request(key_request(reverse ? KEY_SLOTS - 1 - i : i, $urandom));
				sent += KEY_SLOTS;
			end else if (kind < 85) begin
				for (int i = 0; i < burst; i++) begin
					if ($urandom_range(0, 15) == 0)
						send_request(key_request($urandom_range(0, KEY_SLOTS - 1),
							$urandom));
					else
						send_request(block_request(rand64(), rand64()));
				end
				sent += burst;
			end else begin
				for (int i = 0; i < burst; i++) begin
					it.mode       = mode_t'(1'($urandom_range(0, 1)));
					it.key_index  = KEY_IDX_W'($urandom_range(0, KEY_SLOTS - 1));
					it.key_word   = $urandom;
					it.block_high = rand64();
					it.block_low  = rand64();
					send_request(it);
				end
				sent += burst;
			end
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off counted here
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				stall_left = hold_off_cycles;
				hold_off_cycles = 0;
			end else if (stall_left == 0 && $urandom_range(0, 99) < 25) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each taken result against the oldest prediction.
	always @(negedge clk) begin : check_results
		sm4_block_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_blocks.size() == 0) begin
				$display("%0t: result with none expected: %h %h", $time,
					rsp_ch.result_high, rsp_ch.result_low);
				errors++;
			end else begin
				want = expected_blocks.pop_front();
				if (rsp_ch.result_high !== want.result_high) begin
					$display("%0t: result_high expected %h actual %h", $time,
						want.result_high, rsp_ch.result_high);
					errors++;
				end
				if (rsp_ch.result_low !== want.result_low) begin
					$display("%0t: result_low expected %h actual %h", $time,
						want.result_low, rsp_ch.result_low);
					errors++;
				end
			end
		end
	end

	// End the run if nothing moves on either channel for too long.
	always @(negedge clk) begin : watchdog
		int idle_cycles;
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		errors          = 0;
		hold_off_cycles = 0;
		steady          = 1'b0;
		req_up          = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = MODE_KEY;
		req_ch.key_index  = '0;
		req_ch.key_word   = '0;
		req_ch.block_high = '0;
		req_ch.block_low  = '0;
		for (int i = 0; i < KEY_SLOTS; i++)
			key_copy[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_fill();
		test_block_extremes();
		test_key_update_order();
		test_decrypt();
		test_backpressure();
		test_drain_pause();
		test_random();

		// Let the tail of the pipeline flush, key loads included.
		wait_drained();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sm4_pkg.sv
rtl/core/sm4_ifs.sv
rtl/core/sm4_stage.sv
rtl/core/sm4_block_cipher.sv
tb/sv/tb.sv
